[rtl/bav_pkg.sv]
// Shared constants, types and tables for the barometric altimeter.
package bav_pkg;

  // Averaging ring
  localparam int unsigned AVG_LOG   = 3;
  localparam int unsigned AVG_DEPTH = 1 << AVG_LOG;
  localparam int unsigned SLOT_W    = (AVG_LOG > 0) ? AVG_LOG : 1;
  localparam int unsigned SUM_W     = 24 + AVG_LOG;

  // Field widths
  localparam int unsigned PRES_W = 24;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned ALT_W  = 27;
  localparam int unsigned SPD_W  = 32;

  // Divider widths
  localparam int unsigned DIVD_W = 48;
  localparam int unsigned DIVR_W = 24;

  // Arithmetic constants
  localparam logic [PRES_W-1:0]   GP_RESET   = 24'd6484800;
  localparam logic signed [26:0]  FULL_MM    = 27'sd44330000;
  localparam logic signed [26:0]  ALT_MIN_MM = -27'sd10000000;
  localparam logic signed [22:0]  LOG_SCALE  = 23'sd3192620;

  // Factors 2^(2^-k) in Q.30 for k = 1..24
  typedef logic [30:0] sq_tab_t [24];

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = x;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic sq_tab_t build_sq_tab();
    sq_tab_t     tab;
    logic [63:0] s;
    s = 64'd2 << 30;
    for (int k = 0; k < 24; k++) begin
      s      = isqrt64(s << 30);
      tab[k] = s[30:0];
    end
    return tab;
  endfunction

endpackage

[rtl/bav_if.sv]
// Channel interfaces: input item, result item and ground-pressure write.
interface bav_in_if;
  logic                      valid;
  logic                      ready;
  logic [bav_pkg::PRES_W-1:0] pressure_sample;
  logic [bav_pkg::MS_W-1:0]   elapsed_ms;
  modport source (output valid, output pressure_sample, output elapsed_ms, input ready);
  modport sink   (input valid, input pressure_sample, input elapsed_ms, output ready);
endinterface

interface bav_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bav_pkg::ALT_W-1:0] altitude_mm;
  logic signed [bav_pkg::SPD_W-1:0] vertical_speed;
  logic                             speed_valid;
  modport source (output valid, output altitude_mm, output vertical_speed,
                  output speed_valid, input ready);
  modport sink   (input valid, input altitude_mm, input vertical_speed,
                  input speed_valid, output ready);
endinterface

interface bav_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bav_pkg::PRES_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/baro_altimeter_avg_vspeed_top.sv]
// Barometric altimeter top level: sequencer, log2/exp2 datapath, result register.
// Steps from input accept to result load: two 48-bit divisions, a normalize loop,
// 24 log2 squarings and 24 exp2 products;
// a zero ratio skips the log2/exp2 path, zero elapsed time skips the speed division.
// One item in flight; input ready again the cycle after the result loads.
// Reset: ring valid bits, sum, slot and last altitude clear; ground pressure 6484800.
module baro_altimeter_avg_vspeed_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bav_in_if.sink      in_i,
  bav_out_if.source   out_o,
  bav_cfg_if.sink     cfg_i
);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_RING  = 13'b0000000000010,
    ST_DIVR  = 13'b0000000000100,
    ST_NORM  = 13'b0000000001000,
    ST_LOG   = 13'b0000000010000,
    ST_EMUL  = 13'b0000000100000,
    ST_EXP   = 13'b0000001000000,
    ST_SHIFT = 13'b0000010000000,
    ST_AMUL  = 13'b0000100000000,
    ST_SAT   = 13'b0001000000000,
    ST_SPD   = 13'b0010000000000,
    ST_SDIV  = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_e;

  localparam bav_pkg::sq_tab_t SQ_TAB = bav_pkg::build_sq_tab();

  state_e state_q, state_d;

  logic [bav_pkg::PRES_W-1:0]        gp_q;
  logic [bav_pkg::MS_W-1:0]          elapsed_q;
  logic signed [bav_pkg::ALT_W-1:0]  last_q;
  logic signed [bav_pkg::ALT_W-1:0]  alt_q;
  logic signed [27:0]                alt_raw_q;
  logic [47:0]                       norm_q;
  logic [5:0]                        p_q;
  logic [24:0]                       m_q;
  logic [23:0]                       frac_q;
  logic [4:0]                        k_q;
  logic signed [29:0]                e_q;
  logic [23:0]                       f_q;
  logic [30:0]                       acc_q;
  logic signed [31:0]                diff_q;
  logic                              neg_q;
  logic                              out_vld_q;
  logic signed [bav_pkg::ALT_W-1:0]  out_alt_q;
  logic signed [bav_pkg::SPD_W-1:0]  out_spd_q;
  logic                              out_sv_q;

  logic                              accept;
  logic                              ring_done;
  logic [bav_pkg::PRES_W-1:0]        ring_avg;
  logic                              div_start;
  logic [bav_pkg::DIVD_W-1:0]        div_dvd;
  logic [bav_pkg::DIVR_W-1:0]        div_dvs;
  logic                              div_done;
  logic [bav_pkg::DIVD_W-1:0]        div_q;
  logic [bav_pkg::PRES_W-1:0]        gp_eff;
  logic                              load_out;

  logic [49:0]                       sq_prod;
  logic [25:0]                       sq_t;
  logic signed [30:0]                l_s;
  logic signed [53:0]                l_prod;
  logic signed [5:0]                 ei_s;
  logic [4:0]                        lsh;
  logic [5:0]                        rsh;
  logic [50:0]                       pw;
  logic [61:0]                       acc_prod;
  logic signed [58:0]                alt_prod;
  logic signed [27:0]                dd;
  logic signed [37:0]                num;
  logic [37:0]                       mag;
  logic signed [bav_pkg::SPD_W-1:0]  spd_sat;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign gp_eff    = (gp_q == '0) ? bav_pkg::PRES_W'(1) : gp_q;
  assign load_out  = (state_q == ST_FIN) && (!out_vld_q || out_o.ready);

  bav_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (in_i.pressure_sample),
    .done_o   (ring_done),
    .avg_o    (ring_avg)
  );

  // Shared divider: pressure ratio, then speed
  assign div_start = ((state_q == ST_RING) && ring_done) ||
                     ((state_q == ST_SPD) && (elapsed_q != '0));
  assign div_dvd = (state_q == ST_RING) ? {ring_avg, 24'd0}
                                        : {10'd0, mag};
  assign div_dvs = (state_q == ST_RING) ? gp_eff
                                        : {8'd0, elapsed_q};

  bav_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // log2 squaring step
  assign sq_prod = m_q * m_q;
  assign sq_t    = sq_prod[49:24];

  // log2 result times 1/5.255
  assign l_s    = {7'(7'(p_q) - 7'd24), frac_q};
  assign l_prod = l_s * bav_pkg::LOG_SCALE;

  // exp2 product step
  assign acc_prod = acc_q * SQ_TAB[k_q];

  // Integer part of exponent
  assign ei_s = e_q[29:24];
  assign lsh  = (ei_s > 6'sd20) ? 5'd20 : ei_s[4:0];
  assign rsh  = 6'(-ei_s);
  assign pw   = ei_s[5] ? ({20'd0, acc_q} >> rsh) : ({20'd0, acc_q} << lsh);

  // Altitude scale
  assign alt_prod = diff_q * bav_pkg::FULL_MM;

  // Speed numerator
  assign dd  = 28'(alt_q) - 28'(last_q);
  assign num = 38'(dd) * 38'sd1000;
  assign mag = num[37] ? 38'(-num) : 38'(num);

  // Speed saturation
  always_comb begin
    if (neg_q) begin
      spd_sat = (div_q > 48'h0000_8000_0000) ? 32'sh8000_0000
                                            : 32'(-$signed({1'b0, div_q[31:0]}));
    end else begin
      spd_sat = (div_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_RING;
      ST_RING:  if (ring_done) state_d = ST_DIVR;
      ST_DIVR: begin
        if (div_done) state_d = (div_q == '0) ? ST_SPD : ST_NORM;
      end
      ST_NORM:  if (norm_q[47]) state_d = ST_LOG;
      ST_LOG:   if (k_q == 5'd23) state_d = ST_EMUL;
      ST_EMUL:  state_d = ST_EXP;
      ST_EXP:   if (k_q == 5'd23) state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_AMUL;
      ST_AMUL:  state_d = ST_SAT;
      ST_SAT:   state_d = ST_SPD;
      ST_SPD:   state_d = (elapsed_q == '0) ? ST_FIN : ST_SDIV;
      ST_SDIV:  if (div_done) state_d = ST_FIN;
      ST_FIN:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= in_i.elapsed_ms;
    end
    case (state_q)
      ST_DIVR: begin
        if (div_done) begin
          norm_q <= div_q;
          // Zero ratio gives full-scale altitude
          if (div_q == '0) alt_q <= bav_pkg::FULL_MM;
        end
      end
      ST_NORM: begin
        if (norm_q[47]) begin
          m_q    <= norm_q[47:23];
          frac_q <= '0;
        end else begin
          norm_q <= {norm_q[46:0], 1'b0};
        end
      end
      ST_LOG: begin
        m_q    <= sq_t[25] ? sq_t[25:1] : sq_t[24:0];
        frac_q <= {frac_q[22:0], sq_t[25]};
      end
      ST_EMUL: begin
        e_q   <= l_prod[53:24];
        f_q   <= l_prod[47:24];
        acc_q <= 31'd1 << 30;
      end
      ST_EXP: begin
        if (f_q[23]) acc_q <= acc_prod[60:30];
        f_q <= {f_q[22:0], 1'b0};
      end
      ST_SHIFT: begin
        if (pw > 51'(3) << 29) diff_q <= -32'sd536870912;
        else                   diff_q <= 32'(51'd1073741824 - pw);
      end
      ST_AMUL: begin
        alt_raw_q <= alt_prod[57:30];
      end
      ST_SAT: begin
        if (alt_raw_q < 28'(bav_pkg::ALT_MIN_MM))   alt_q <= bav_pkg::ALT_MIN_MM;
        else if (alt_raw_q > 28'(bav_pkg::FULL_MM)) alt_q <= bav_pkg::FULL_MM;
        else                                         alt_q <= alt_raw_q[26:0];
      end
      ST_SPD: begin
        neg_q <= num[37];
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gp_q    <= bav_pkg::GP_RESET;
      last_q  <= '0;
      p_q     <= '0;
      k_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) gp_q <= cfg_i.data;
      if (state_q == ST_DIVR) p_q <= 6'd47;
      if (state_q == ST_NORM && !norm_q[47]) p_q <= p_q - 1'b1;
      if ((state_q == ST_LOG) || (state_q == ST_EXP)) k_q <= k_q + 1'b1;
      else                                            k_q <= '0;
      if (load_out) begin
        out_vld_q <= 1'b1;
        last_q    <= alt_q;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_alt_q <= alt_q;
      out_sv_q  <= (elapsed_q != '0);
      out_spd_q <= (elapsed_q != '0) ? spd_sat : '0;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.altitude_mm    = out_alt_q;
  assign out_o.vertical_speed = out_spd_q;
  assign out_o.speed_valid    = out_sv_q;

endmodule

[rtl/bav_ring.sv]
// Sample ring memory with running sum, read-modify-write per item.
module bav_ring (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bav_pkg::PRES_W-1:0]   sample_i,
  output logic                         done_o,
  output logic [bav_pkg::PRES_W-1:0]   avg_o
);

  logic [bav_pkg::PRES_W-1:0]  mem [bav_pkg::AVG_DEPTH];
  logic [bav_pkg::AVG_DEPTH-1:0] vld_q;
  logic [bav_pkg::PRES_W-1:0]  rd_q;
  logic                        rd_vld_q;
  logic [bav_pkg::PRES_W-1:0]  sample_q;
  logic [bav_pkg::SLOT_W-1:0]  slot_q;
  logic [bav_pkg::SUM_W-1:0]   sum_q;
  logic                        upd_q;
  logic                        done_q;
  logic [bav_pkg::PRES_W-1:0]  old_val;
  logic [bav_pkg::SUM_W-1:0]   sum_d;
  logic [bav_pkg::SLOT_W-1:0]  slot_d;

  // Entry never written reads as zero
  assign old_val = rd_vld_q ? rd_q : '0;
  assign sum_d   = sum_q - bav_pkg::SUM_W'(old_val) + bav_pkg::SUM_W'(sample_q);
  assign slot_d  = (32'(slot_q) + 32'd1 >= 32'(bav_pkg::AVG_DEPTH)) ? '0 : slot_q + 1'b1;

  // Memory read and write ports
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rd_q     <= mem[slot_q];
      sample_q <= sample_i;
    end
    if (upd_q) begin
      mem[slot_q] <= sample_q;
    end
  end

  // Control, valid bits and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      slot_q   <= '0;
      sum_q    <= '0;
      upd_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      upd_q  <= start_i;
      done_q <= upd_q;
      if (start_i) begin
        rd_vld_q <= vld_q[slot_q];
      end
      if (upd_q) begin
        vld_q[slot_q] <= 1'b1;
        sum_q         <= sum_d;
        slot_q        <= slot_d;
      end
    end
  end

  assign done_o = done_q;
  assign avg_o  = sum_q[bav_pkg::SUM_W-1:bav_pkg::AVG_LOG];

endmodule

[rtl/bav_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module bav_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bav_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [bav_pkg::DIVR_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [bav_pkg::DIVD_W-1:0]   quot_o
);

  localparam int unsigned CNT_W = $clog2(bav_pkg::DIVD_W + 1);

  logic [bav_pkg::DIVD_W-1:0] quot_q;
  logic [bav_pkg::DIVR_W-1:0] rem_q;
  logic [bav_pkg::DIVR_W-1:0] dvs_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [bav_pkg::DIVR_W:0]   trial;
  logic                       ge;

  assign trial = {rem_q, quot_q[bav_pkg::DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[bav_pkg::DIVD_W-2:0], ge};
      rem_q  <= ge ? bav_pkg::DIVR_W'(trial - {1'b0, dvs_q})
                   : trial[bav_pkg::DIVR_W-1:0];
    end
  end

  // Iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(bav_pkg::DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
